[src/rcfd_pkg.sv]
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants of the remote-control frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int STORE_LEN  = 17;
  localparam int FRAME_LEN  = 18;
  localparam int CNT_W      = 5;
  localparam int FIFO_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 2'd3;

  localparam logic [10:0] CENTER_OFFSET_RST = 11'd1024;
  localparam logic [7:0]  DEAD_BAND_RST     = 8'd10;
  localparam logic [10:0] STICK_LIMIT_RST   = 11'd660;
  localparam logic [10:0] ERROR_LIMIT_RST   = 11'd700;

  localparam int OUT_TDATA_W = 168;

  typedef struct packed {
    logic [10:0] center_offset;
    logic [7:0]  dead_band;
    logic [10:0] stick_limit;
    logic [10:0] error_limit;
  } cfg_t;

  // bytes 0..16 plus the closing byte
  typedef struct packed {
    logic [7:0]                 last;
    logic [STORE_LEN-1:0][7:0]  bytes;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[src/rc_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rc_frame_decoder
// Remote-control frame decoder: 18 bytes in, one decoded frame out.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tdata byte_value, tuser frame_start
// out_     out  out_tvalid/out_tready  tdata decoded fields, tuser frame_error
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One byte is taken every cycle while in_tready is high; a frame is queued on
// its 18th byte, and the back end decodes the queue head into the output register.
// The frame queue (FIFO_DEPTH frames) decouples byte intake from the output;
// in_tready drops only while the queue is full. cfg_ready is always high.
// Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rc_frame_decoder #(
  parameter int FIFO_DEPTH = rcfd_pkg::FIFO_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,  // [7:0] byte_value
  input  logic                               in_tuser,  // [0] frame_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [11:0] stick_0, [23:12] stick_1, [35:24] stick_2, [47:36] stick_3,
  // [63:48] dial, [67:64] switches, [99:68] mouse_xy, [115:100] mouse_z,
  // [131:116] mouse_buttons, [147:132] keys, [163:148] key_changes
  output logic [rcfd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser, // [0] frame_error
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rcfd_pkg::cfg_t       cfg_r;
  rcfd_pkg::frame_t     push_frame, head;
  rcfd_pkg::fifo_stat_t stat;
  logic                 push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_offset <= rcfd_pkg::CENTER_OFFSET_RST;
      cfg_r.dead_band     <= rcfd_pkg::DEAD_BAND_RST;
      cfg_r.stick_limit   <= rcfd_pkg::STICK_LIMIT_RST;
      cfg_r.error_limit   <= rcfd_pkg::ERROR_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcfd_pkg::CFG_CENTER_OFFSET: cfg_r.center_offset <= cfg_data;
        rcfd_pkg::CFG_DEAD_BAND:     cfg_r.dead_band     <= cfg_data[7:0];
        rcfd_pkg::CFG_STICK_LIMIT:   cfg_r.stick_limit   <= cfg_data;
        rcfd_pkg::CFG_ERROR_LIMIT:   cfg_r.error_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  rcfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .stat       (stat),
    .push       (push),
    .push_frame (push_frame)
  );

  rcfd_fifo #(
    .WIDTH (rcfd_pkg::FRAME_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_frame),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  rcfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[src/rcfd_front.sv]
// ----------------------------------------------------------------------------
// rcfd_front
// Accepts frame bytes, tracks the byte position and hands complete frames
// to the frame queue.
// ----------------------------------------------------------------------------
module rcfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // byte_value
  input  logic                in_tuser,   // frame_start
  input  rcfd_pkg::fifo_stat_t stat,
  output logic                push,
  output rcfd_pkg::frame_t    push_frame
);

  logic [rcfd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                 store_r [rcfd_pkg::STORE_LEN];
  logic                       accept;
  logic                       wr_en;
  logic [rcfd_pkg::CNT_W-1:0] wr_idx;

  assign in_tready = !stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    wr_en   = 1'b0;
    wr_idx  = cnt_r;
    push    = 1'b0;
    if (accept) begin
      if (in_tuser) begin
        wr_en   = 1'b1;
        wr_idx  = '0;
        cnt_nxt = rcfd_pkg::CNT_W'(1);
      end else if (cnt_r == '0) begin
        // stray byte outside a frame: dropped
        cnt_nxt = cnt_r;
      end else if (cnt_r < rcfd_pkg::CNT_W'(rcfd_pkg::STORE_LEN)) begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + rcfd_pkg::CNT_W'(1);
      end else begin
        push    = 1'b1;
        cnt_nxt = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < rcfd_pkg::STORE_LEN; i++) begin
      push_frame.bytes[i] = store_r[i];
    end
    push_frame.last = in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= in_tdata;
    end
  end

endmodule

[src/rcfd_fifo.sv]
// ----------------------------------------------------------------------------
// rcfd_fifo
// Short frame queue between the byte front end and the decode back end.
// ----------------------------------------------------------------------------
module rcfd_fifo #(
  parameter int WIDTH = rcfd_pkg::FRAME_W,
  parameter int DEPTH = rcfd_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     head,
  output rcfd_pkg::fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/rcfd_back.sv]
// ----------------------------------------------------------------------------
// rcfd_back
// Decodes one queued frame per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module rcfd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rcfd_pkg::cfg_t                      cfg,
  input  rcfd_pkg::frame_t                    head,
  input  rcfd_pkg::fifo_stat_t                stat,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rcfd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser
);

  logic                             out_valid_r;
  logic [rcfd_pkg::OUT_TDATA_W-1:0] tdata_r, tdata_nxt;
  logic                             err_r, err_nxt;
  logic [15:0]                      prev_keys_r, prev_keys_nxt;

  function automatic logic [11:0] stick_off(logic [10:0] raw, logic [10:0] ctr);
    stick_off = {1'b0, raw} - {1'b0, ctr};
  endfunction

  function automatic logic [10:0] mag11(logic [11:0] v);
    mag11 = v[11] ? 11'(-v) : v[10:0];
  endfunction

  assign pop = !stat.empty && (!out_valid_r || out_tready);

  always_comb begin
    logic [10:0] raw [4];
    logic [11:0] off [4];
    logic [11:0] st  [4];
    logic [10:0] m   [4];
    logic        over, big;
    logic [3:0]  sw;
    logic [15:0] dial, mx, my, mz, btn, keys;

    raw[0] = {head.bytes[1][2:0], head.bytes[0]};
    raw[1] = {head.bytes[2][5:0], head.bytes[1][7:3]};
    raw[2] = {head.bytes[4][0], head.bytes[3], head.bytes[2][7:6]};
    raw[3] = {head.bytes[5][3:0], head.bytes[4][7:1]};
    over = 1'b0;
    big  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      off[i] = stick_off(raw[i], cfg.center_offset);
      m[i]   = mag11(off[i]);
      if (m[i] <= {3'b0, cfg.dead_band}) begin
        st[i] = '0;
        m[i]  = '0;
      end else begin
        st[i] = off[i];
      end
      if (m[i] > cfg.stick_limit) over = 1'b1;
      if (m[i] > cfg.error_limit) big  = 1'b1;
    end
    sw   = head.bytes[5][7:4];
    dial = {head.last, head.bytes[16]} - {5'b0, cfg.center_offset};
    mx   = 16'(-{head.bytes[7], head.bytes[6]});
    my   = 16'(-{head.bytes[9], head.bytes[8]});
    mz   = {head.bytes[11], head.bytes[10]};
    btn  = {head.bytes[13], head.bytes[12]};
    keys = {head.bytes[15], head.bytes[14]};

    // a stick over the stick limit always makes an error frame
    err_nxt = over || big || (sw[1:0] == 2'b00) || (sw[3:2] == 2'b00);
    if (err_nxt) begin
      tdata_nxt     = '0;
      prev_keys_nxt = '0;
    end else begin
      tdata_nxt     = {4'b0, keys ^ prev_keys_r, keys, btn, mz, my, mx, sw, dial,
                       st[3], st[2], st[1], st[0]};
      prev_keys_nxt = keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_keys_r <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        prev_keys_r <= prev_keys_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tdata_r <= tdata_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = err_r;

endmodule

[src/rcfd_checker.sv]
// ----------------------------------------------------------------------------
// rcfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rcfd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rcfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error frame carries data");

  a_sw_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[65:64] != 2'b00 && out_tdata[67:66] != 2'b00)
    else $error("good frame with a zero switch");

endmodule

bind rc_frame_decoder rcfd_checker u_rcfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
